>>> rtl/rgbm_pkg.sv
// ============================================================================
// rgbm_pkg
// Shared constants and types of the RGB matrix scan and PWM driver.
// ============================================================================
`default_nettype none

package rgbm_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 32;

    localparam int COLOR_W    = 8;
    localparam int PIX_W      = 3 * COLOR_W;
    localparam int INDEX_W    = 11;
    localparam int ROW_W      = 4;
    localparam int COL_W      = 7;
    localparam int HEIGHT_W   = 6;
    localparam int PWM_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int ADDR_CALC_W = 15;
    localparam int THR_W      = 2 * PWM_W + 1;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PANEL_WIDTH  = 2'd0,
        REG_PANEL_HEIGHT = 2'd1,
        REG_PWM_TOP      = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             latch;
        logic [ROW_W-1:0] row;
        logic [THR_W-1:0] thr;
        logic             top_blank;
        logic             bot_blank;
    } scan_tag_t;

endpackage

`default_nettype wire

>>> rtl/rgbm_frame_mem.sv
// ============================================================================
// rgbm_frame_mem
// Frame store: one write port and two read ports with registered read data.
// ============================================================================
`default_nettype none

module rgbm_frame_mem #(
    parameter int DEPTH = rgbm_pkg::MAX_WIDTH_DEF * rgbm_pkg::MAX_HEIGHT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [AW-1:0]              waddr,
    input  wire logic [rgbm_pkg::PIX_W-1:0] wdata,
    input  wire logic                       re,
    input  wire logic [AW-1:0]              raddr_top,
    input  wire logic [AW-1:0]              raddr_bot,
    output logic      [rgbm_pkg::PIX_W-1:0] rdata_top,
    output logic      [rgbm_pkg::PIX_W-1:0] rdata_bot
);
    import rgbm_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_top_reg;
    logic [PIX_W-1:0] rdata_bot_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_top_reg <= mem[raddr_top];
            rdata_bot_reg <= mem[raddr_bot];
        end
    end

    assign rdata_top = rdata_top_reg;
    assign rdata_bot = rdata_bot_reg;

endmodule

`default_nettype wire

>>> rtl/rgbm_scan_ctrl.sv
// ============================================================================
// rgbm_scan_ctrl
// Configuration registers, scan counters, frame store addressing and the
// clearing sweep that blanks the frame store after reset.
// ============================================================================
`default_nettype none

module rgbm_scan_ctrl #(
    parameter int MAX_WIDTH  = rgbm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rgbm_pkg::MAX_HEIGHT_DEF,
    parameter int DEPTH      = MAX_WIDTH * MAX_HEIGHT,
    parameter int AW         = $clog2(DEPTH)
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_fire,
    input  wire logic [rgbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rgbm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            tick_fire,
    input  wire logic                            write_fire,
    input  wire logic [rgbm_pkg::INDEX_W-1:0]    pixel_index,
    input  wire logic [rgbm_pkg::PIX_W-1:0]      pixel_data,
    output logic                                 clearing,
    output logic                                 mem_we,
    output logic      [AW-1:0]                   mem_waddr,
    output logic      [rgbm_pkg::PIX_W-1:0]      mem_wdata,
    output logic      [AW-1:0]                   raddr_top,
    output logic      [AW-1:0]                   raddr_bot,
    output rgbm_pkg::scan_tag_t                  tag,
    output logic      [rgbm_pkg::PWM_W-1:0]      pwm_top
);
    import rgbm_pkg::*;

    localparam int HALF_MAX = MAX_HEIGHT / 2;

    logic [COL_W-1:0]    width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [PWM_W-1:0]    top_reg;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [PWM_W-1:0]    cnt_reg, cnt_next;
    logic                clr_active_reg;
    logic [AW-1:0]       clr_addr_reg;

    logic [COL_W:0]         w_eff;
    logic [ROW_W:0]         half;
    logic [ADDR_CALC_W-1:0] top_idx, bot_idx;
    logic                   row_end, row_last;
    logic [PWM_W:0]         cnt_inc;
    logic                   wr_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= COL_W'(64);
            height_reg <= HEIGHT_W'(32);
            top_reg    <= PWM_W'(255);
        end else if (cfg_fire) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PANEL_WIDTH:  width_reg  <= cfg_data[COL_W-1:0];
                REG_PANEL_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_PWM_TOP:      top_reg    <= cfg_data[PWM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff = {1'b0, width_reg};
        if (width_reg == '0) begin
            w_eff = (COL_W+1)'(1);
        end
        if (w_eff > (COL_W+1)'(MAX_WIDTH)) begin
            w_eff = (COL_W+1)'(MAX_WIDTH);
        end
        half = (ROW_W+1)'(height_reg[HEIGHT_W-1:1]);
        if (half == '0) begin
            half = (ROW_W+1)'(1);
        end
        if (half > (ROW_W+1)'(HALF_MAX)) begin
            half = (ROW_W+1)'(HALF_MAX);
        end
    end

    always_comb begin
        top_idx = ADDR_CALC_W'(row_reg) * ADDR_CALC_W'(w_eff) + ADDR_CALC_W'(col_reg);
        bot_idx = (ADDR_CALC_W'(half) + ADDR_CALC_W'(row_reg)) * ADDR_CALC_W'(w_eff)
                  + ADDR_CALC_W'(col_reg);
        row_end  = ({1'b0, col_reg} + (COL_W+1)'(1)) >= w_eff;
        row_last = ({1'b0, row_reg} + (ROW_W+1)'(1)) >= half;
        cnt_inc  = {1'b0, cnt_reg} + (PWM_W+1)'(1);

        row_next = row_reg;
        col_next = col_reg;
        cnt_next = cnt_reg;
        if (row_end) begin
            col_next = '0;
            if (row_last) begin
                row_next = '0;
                cnt_next = (cnt_reg >= top_reg) ? '0 : cnt_inc[PWM_W-1:0];
            end else begin
                row_next = row_reg + ROW_W'(1);
            end
        end else begin
            col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
            cnt_reg <= '0;
        end else if (tick_fire) begin
            row_reg <= row_next;
            col_reg <= col_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    assign wr_ok    = ADDR_CALC_W'(pixel_index) < ADDR_CALC_W'(DEPTH);
    assign clearing = clr_active_reg;

    always_comb begin
        if (clr_active_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = write_fire && wr_ok;
            mem_waddr = AW'(pixel_index);
            mem_wdata = pixel_data;
        end
    end

    assign raddr_top = top_idx[AW-1:0];
    assign raddr_bot = bot_idx[AW-1:0];
    assign pwm_top   = top_reg;

    always_comb begin
        tag.latch     = row_end;
        tag.row       = row_end ? row_reg : '0;
        tag.thr       = {cnt_inc, PWM_W'(0)} - THR_W'(cnt_inc);
        tag.top_blank = top_idx >= ADDR_CALC_W'(DEPTH);
        tag.bot_blank = bot_idx >= ADDR_CALC_W'(DEPTH);
    end

endmodule

`default_nettype wire

>>> rtl/rgbm_pwm_out.sv
// ============================================================================
// rgbm_pwm_out
// Read stage and result register: scales each colour by the PWM ceiling,
// compares it with the PWM count and holds the result item for the sink.
// ============================================================================
`default_nettype none

module rgbm_pwm_out (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        tick_fire,
    input  wire rgbm_pkg::scan_tag_t         tag_in,
    input  wire logic [rgbm_pkg::PWM_W-1:0]  pwm_top,
    input  wire logic [rgbm_pkg::PIX_W-1:0]  rdata_top,
    input  wire logic [rgbm_pkg::PIX_W-1:0]  rdata_bot,
    output logic                             pipe_free,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_top_red_on,
    output logic                             m_top_green_on,
    output logic                             m_top_blue_on,
    output logic                             m_bottom_red_on,
    output logic                             m_bottom_green_on,
    output logic                             m_bottom_blue_on,
    output logic                             m_latch_pulse,
    output logic      [rgbm_pkg::ROW_W-1:0]  m_row_address
);
    import rgbm_pkg::*;

    function automatic logic pwm_bit(logic [COLOR_W-1:0] c, logic [PWM_W-1:0] top,
                                     logic [THR_W-1:0] thr);
        logic [2*PWM_W-1:0] prod;
        prod = (2*PWM_W)'(c) * (2*PWM_W)'(top);
        return {1'b0, prod} >= thr;
    endfunction

    logic             s1_valid_reg;
    scan_tag_t        s1_tag_reg;
    logic             out_valid_reg;
    logic [5:0]       bits_reg, bits_next;
    logic             latch_reg;
    logic [ROW_W-1:0] row_reg;
    logic             adv_out;
    logic [PIX_W-1:0] top_px, bot_px;

    assign adv_out   = !out_valid_reg || m_ready;
    assign pipe_free = !s1_valid_reg || adv_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (tick_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (adv_out) begin
                s1_valid_reg <= 1'b0;
            end
            if (adv_out) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_fire) begin
            s1_tag_reg <= tag_in;
        end
    end

    always_comb begin
        top_px = s1_tag_reg.top_blank ? '0 : rdata_top;
        bot_px = s1_tag_reg.bot_blank ? '0 : rdata_bot;
        bits_next[5] = pwm_bit(top_px[23:16], pwm_top, s1_tag_reg.thr);
        bits_next[4] = pwm_bit(top_px[15:8],  pwm_top, s1_tag_reg.thr);
        bits_next[3] = pwm_bit(top_px[7:0],   pwm_top, s1_tag_reg.thr);
        bits_next[2] = pwm_bit(bot_px[23:16], pwm_top, s1_tag_reg.thr);
        bits_next[1] = pwm_bit(bot_px[15:8],  pwm_top, s1_tag_reg.thr);
        bits_next[0] = pwm_bit(bot_px[7:0],   pwm_top, s1_tag_reg.thr);
    end

    always_ff @(posedge aclk) begin
        if (adv_out && s1_valid_reg) begin
            bits_reg  <= bits_next;
            latch_reg <= s1_tag_reg.latch;
            row_reg   <= s1_tag_reg.row;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_top_red_on      = bits_reg[5];
    assign m_top_green_on    = bits_reg[4];
    assign m_top_blue_on     = bits_reg[3];
    assign m_bottom_red_on   = bits_reg[2];
    assign m_bottom_green_on = bits_reg[1];
    assign m_bottom_blue_on  = bits_reg[0];
    assign m_latch_pulse     = latch_reg;
    assign m_row_address     = row_reg;

endmodule

`default_nettype wire

>>> rtl/rgb_matrix_scan_pwm_driver.sv
// ============================================================================
// rgb_matrix_scan_pwm_driver
// Scan driver for a two-half RGB LED panel with a frame store of 24-bit
// pixels and per-colour PWM against a frame-rate PWM count.
//
//   Channel  Ports                        Direction  Moves
//   s_       s_valid / s_ready + fields   in         write or tick item
//   m_       m_valid / m_ready + fields   out        shifted bits per tick
//   cfg_     cfg_valid / cfg_ready        in         register write
//
// One item is accepted per cycle while s_ready is high; a tick's result
// passes through the registered read of the frame memory and the result
// register. After reset a clearing pass writes black to all entries of
// MAX_WIDTH*MAX_HEIGHT (2048 by default), one per cycle, with s_ready low.
// A stalled m_ready backs up through the read stage and the result register.
// Configuration writes are always taken.
// ============================================================================
`default_nettype none

module rgb_matrix_scan_pwm_driver #(
    parameter int MAX_WIDTH  = rgbm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rgbm_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rgbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rgbm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_opcode,
    input  wire logic [rgbm_pkg::INDEX_W-1:0]    s_pixel_index,
    input  wire logic [rgbm_pkg::COLOR_W-1:0]    s_red,
    input  wire logic [rgbm_pkg::COLOR_W-1:0]    s_green,
    input  wire logic [rgbm_pkg::COLOR_W-1:0]    s_blue,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_top_red_on,
    output logic                                 m_top_green_on,
    output logic                                 m_top_blue_on,
    output logic                                 m_bottom_red_on,
    output logic                                 m_bottom_green_on,
    output logic                                 m_bottom_blue_on,
    output logic                                 m_latch_pulse,
    output logic      [rgbm_pkg::ROW_W-1:0]      m_row_address
);
    import rgbm_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic             clearing;
    logic             pipe_free;
    logic             accept, tick_fire, write_fire;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr, raddr_top, raddr_bot;
    logic [PIX_W-1:0] mem_wdata, rdata_top, rdata_bot;
    scan_tag_t        tag;
    logic [PWM_W-1:0] pwm_top;

    assign cfg_ready  = 1'b1;
    assign s_ready    = !clearing && pipe_free;
    assign accept     = s_valid && s_ready;
    assign tick_fire  = accept && (s_opcode == OP_TICK);
    assign write_fire = accept && (s_opcode == OP_WRITE);

    rgbm_scan_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH      (DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_fire    (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .tick_fire   (tick_fire),
        .write_fire  (write_fire),
        .pixel_index (s_pixel_index),
        .pixel_data  ({s_red, s_green, s_blue}),
        .clearing    (clearing),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .raddr_top   (raddr_top),
        .raddr_bot   (raddr_bot),
        .tag         (tag),
        .pwm_top     (pwm_top)
    );

    rgbm_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk      (aclk),
        .we        (mem_we),
        .waddr     (mem_waddr),
        .wdata     (mem_wdata),
        .re        (tick_fire),
        .raddr_top (raddr_top),
        .raddr_bot (raddr_bot),
        .rdata_top (rdata_top),
        .rdata_bot (rdata_bot)
    );

    rgbm_pwm_out u_out (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .tick_fire         (tick_fire),
        .tag_in            (tag),
        .pwm_top           (pwm_top),
        .rdata_top         (rdata_top),
        .rdata_bot         (rdata_bot),
        .pipe_free         (pipe_free),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_top_red_on      (m_top_red_on),
        .m_top_green_on    (m_top_green_on),
        .m_top_blue_on     (m_top_blue_on),
        .m_bottom_red_on   (m_bottom_red_on),
        .m_bottom_green_on (m_bottom_green_on),
        .m_bottom_blue_on  (m_bottom_blue_on),
        .m_latch_pulse     (m_latch_pulse),
        .m_row_address     (m_row_address)
    );

endmodule

`default_nettype wire

>>> rtl/rgbm_checker.sv
// ============================================================================
// rgbm_checker
// Port-level checks of the scan driver, bound to the top level.
// ============================================================================
`default_nettype none

module rgbm_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_valid,
    input wire logic                       s_ready,
    input wire logic                       s_opcode,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic                       m_top_red_on,
    input wire logic                       m_bottom_blue_on,
    input wire logic                       m_latch_pulse,
    input wire logic [rgbm_pkg::ROW_W-1:0] m_row_address
);
    import rgbm_pkg::*;

    // The clearing pass holds off input items right after reset.
    a_clear_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input accepted during frame store clearing");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present right after reset");

    // A fresh result follows an accepted tick through the read and result registers.
    a_result_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid)) |->
            $past(s_valid && s_ready && (s_opcode == OP_TICK), 2))
        else $error("result without a matching tick item");

    a_row_only_on_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_latch_pulse) |-> (m_row_address == '0))
        else $error("row address set without latch pulse");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_top_red_on) && $stable(m_bottom_blue_on)
             && $stable(m_latch_pulse) && $stable(m_row_address)))
        else $error("stalled result item changed");

endmodule

bind rgb_matrix_scan_pwm_driver rgbm_checker u_rgbm_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_opcode         (s_opcode),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_top_red_on     (m_top_red_on),
    .m_bottom_blue_on (m_bottom_blue_on),
    .m_latch_pulse    (m_latch_pulse),
    .m_row_address    (m_row_address)
);

`default_nettype wire
